// ===== rtl/core/ucal_pkg.sv =====
// Shared constants, types and month tables for the Unix-time to UTC calendar pipeline.
// Depends on nothing; all rtl/core files but ucal_if and ucal_checker import it.

package ucal_pkg;

    // Register stages from input beat to output beat
    localparam int STAGES = 11;

    typedef logic [STAGES-1:0] t_stage_en;

    // Day split: the lower ten bits of ms/day are zero, leaving an odd divisor
    localparam int              DAY_SHR_BITS = 10;
    localparam logic [16:0]     DAY_ODD      = 17'd84375;
    localparam int              DAY_SHIFT    = 47;
    localparam logic [30:0]     DAY_RECIP    =
        31'(((64'd1 << DAY_SHIFT) + 64'd84374) / 64'd84375);
    // Bias that keeps the shifted count non-negative (a whole number of days)
    localparam int              DAY_BIAS_DAYS_LOG2 = 21;
    localparam logic [38:0]     DAY_BIAS     = 39'(64'd84375 << DAY_BIAS_DAYS_LOG2);

    // Biased day number: day count from 0000-03-01 plus ten whole eras
    localparam int              ERA_BIAS     = 10;
    localparam logic [22:0]     ZB_OFFSET    =
        23'(64'd1460970 + 64'd719468 - (64'd1 << DAY_BIAS_DAYS_LOG2));
    localparam logic [17:0]     DAYS_PER_ERA = 18'd146097;
    localparam int              ERA_SHIFT    = 41;
    localparam logic [23:0]     ERA_RECIP    =
        24'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);
    localparam logic [14:0]     YEAR_BIAS    = 15'(ERA_BIAS * 400);

    // Day-of-era to year-of-era
    localparam int              Q4Y_SHIFT    = 29;
    localparam logic [18:0]     Q4Y_RECIP    = 19'(((64'd1 << Q4Y_SHIFT) + 64'd1459) / 64'd1460);
    localparam logic [17:0]     CENT_DAYS    = 18'd36524;
    localparam logic [17:0]     ERA_LAST_DAY = 18'd146096;
    localparam int              YEAR_SHIFT   = 27;
    localparam logic [18:0]     YEAR_RECIP   = 19'(((64'd1 << YEAR_SHIFT) + 64'd364) / 64'd365);

    // Time of day
    localparam int              SEC_SHIFT    = 31;
    localparam logic [24:0]     SEC_RECIP    = 25'(((64'd1 << SEC_SHIFT) + 64'd124) / 64'd125);
    localparam int              MIN_SHIFT    = 23;
    localparam logic [17:0]     MIN_RECIP    = 18'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);
    localparam int              HOUR_SHIFT   = 17;
    localparam logic [11:0]     HOUR_RECIP   = 12'(((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60);

    // First day-of-year of each month, counted from March
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Month index from March: count the month starts at or below doy
    function automatic logic [3:0] march_month(input logic [8:0] doy);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (doy >= month_start(4'(k))) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt;
    endfunction

endpackage

// ===== rtl/core/ucal_if.sv =====
// Valid/ready channel interfaces: the millisecond timestamp in, the calendar fields out.
// Depends on nothing.

interface ucal_ms_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] unix_ms;

    modport source (output valid, output unix_ms, input ready);
    modport sink   (input valid, input unix_ms, output ready);
endinterface

interface ucal_cal_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         millisecond;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output millisecond, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input millisecond, output ready);
endinterface

// ===== rtl/core/ucal_pipe_ctl.sv =====
// Valid bits and per-stage load enables for the calendar pipeline; bubbles collapse.
// Depends on ucal_pkg.

module ucal_pipe_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output ucal_pkg::t_stage_en o_en
);
    import ucal_pkg::*;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_rdy;

    // A stage may load when it is empty or the stage after it loads
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Advance valid bits alongside the data
    always_comb begin
        n_vld[0] = w_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < STAGES; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en        = w_rdy;
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[STAGES-1];

endmodule

// ===== rtl/core/ucal_day_split.sv =====
// Stages 1-5: floor-split of signed milliseconds into a biased day number and ms of day.
// Depends on ucal_pkg. Divides by the odd part of ms/day in 10- and 13-bit quotient steps.

module ucal_day_split (
    input  logic                i_clk,
    input  ucal_pkg::t_stage_en i_en,
    input  logic signed [47:0]  i_unix_ms,
    output logic [22:0]         o_zb,
    output logic [26:0]         o_msd
);
    import ucal_pkg::*;

    // Stage 1: drop the low ten bits, bias to a non-negative count
    logic [38:0] r_u1;
    logic [9:0]  r_lo1;
    logic [38:0] n_u1;

    assign n_u1 = {i_unix_ms[47], i_unix_ms[47:DAY_SHR_BITS]} + DAY_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_u1  <= n_u1;
            r_lo1 <= i_unix_ms[DAY_SHR_BITS-1:0];
        end
    end

    // Stage 2: quotient of the upper 26 bits
    logic [56:0] w_p2;
    logic [9:0]  r_q2;
    logic [25:0] r_x2;
    logic [12:0] r_lo2;
    logic [9:0]  r_ms2;

    assign w_p2 = 57'(r_u1[38:13]) * 57'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_q2  <= w_p2[DAY_SHIFT+9:DAY_SHIFT];
            r_x2  <= r_u1[38:13];
            r_lo2 <= r_u1[12:0];
            r_ms2 <= r_lo1;
        end
    end

    // Stage 3: remainder of the upper part
    logic [26:0] w_r3;
    logic [9:0]  r_q3;
    logic [16:0] r_r3;
    logic [12:0] r_lo3;
    logic [9:0]  r_ms3;

    assign w_r3 = 27'(r_x2) - 27'(r_q2) * 27'(DAY_ODD);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_q3  <= r_q2;
            r_r3  <= w_r3[16:0];
            r_lo3 <= r_lo2;
            r_ms3 <= r_ms2;
        end
    end

    // Stage 4: quotient of remainder joined with the low 13 bits
    logic [29:0] w_x4;
    logic [60:0] w_p4;
    logic [29:0] r_x4;
    logic [9:0]  r_qa4;
    logic [12:0] r_qb4;
    logic [9:0]  r_ms4;

    assign w_x4 = {r_r3, r_lo3};
    assign w_p4 = 61'(w_x4) * 61'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_x4  <= w_x4;
            r_qa4 <= r_q3;
            r_qb4 <= w_p4[DAY_SHIFT+12:DAY_SHIFT];
            r_ms4 <= r_ms3;
        end
    end

    // Stage 5: final remainder gives ms of day; rebias the day number
    localparam logic [29:0] DAY_OFF_W = 30'(DAY_ODD);

    logic [29:0] w_r5;
    logic [22:0] r_zb5;
    logic [26:0] r_msd5;

    assign w_r5 = r_x4 - 30'(r_qb4) * 30'(DAY_OFF_W);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_zb5  <= {r_qa4, r_qb4} + ZB_OFFSET;
            r_msd5 <= {w_r5[16:0], r_ms4};
        end
    end

    assign o_zb  = r_zb5;
    assign o_msd = r_msd5;

endmodule

// ===== rtl/core/ucal_civil_date.sv =====
// Stages 6-11: biased day number to proleptic Gregorian year, month and day (era method).
// Depends on ucal_pkg for the reciprocals and month tables.

module ucal_civil_date (
    input  logic                i_clk,
    input  ucal_pkg::t_stage_en i_en,
    input  logic [22:0]         i_zb,
    output logic signed [13:0]  o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day
);
    import ucal_pkg::*;

    // Stage 6: era number
    logic [46:0] w_p6;
    logic [4:0]  r_era6;
    logic [22:0] r_z6;

    assign w_p6 = 47'(i_zb) * 47'(ERA_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_era6 <= w_p6[ERA_SHIFT+4:ERA_SHIFT];
            r_z6   <= i_zb;
        end
    end

    // Stage 7: day of era
    logic [22:0] w_doe7;
    logic [17:0] r_doe7;
    logic [4:0]  r_era7;

    assign w_doe7 = r_z6 - 23'(r_era6) * 23'(DAYS_PER_ERA);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_doe7 <= w_doe7[17:0];
            r_era7 <= r_era6;
        end
    end

    // Stage 8: strip leap days out of the day of era
    logic [36:0] w_p8;
    logic [2:0]  w_cent8;
    logic        w_last8;
    logic [17:0] r_t8;
    logic [17:0] r_doe8;
    logic [14:0] r_yb8;

    assign w_p8    = 37'(r_doe7) * 37'(Q4Y_RECIP);
    assign w_cent8 = 3'(r_doe7 >= CENT_DAYS) + 3'(r_doe7 >= 18'(2 * CENT_DAYS))
                   + 3'(r_doe7 >= 18'(3 * CENT_DAYS)) + 3'(r_doe7 >= ERA_LAST_DAY);
    assign w_last8 = (r_doe7 == ERA_LAST_DAY);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_t8   <= r_doe7 - 18'(w_p8[Q4Y_SHIFT+6:Q4Y_SHIFT]) + 18'(w_cent8) - 18'(w_last8);
            r_doe8 <= r_doe7;
            r_yb8  <= 15'(r_era7) * 15'd400;
        end
    end

    // Stage 9: year of era
    logic [36:0] w_p9;
    logic [8:0]  r_yoe9;
    logic [17:0] r_doe9;
    logic [14:0] r_yb9;

    assign w_p9 = 37'(r_t8) * 37'(YEAR_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_yoe9 <= w_p9[YEAR_SHIFT+8:YEAR_SHIFT];
            r_doe9 <= r_doe8;
            r_yb9  <= r_yb8;
        end
    end

    // Stage 10: day of year from March, and the March-based year
    logic [1:0]  w_c100;
    logic [17:0] w_yd10;
    logic [17:0] w_doy10;
    logic [8:0]  r_doy10;
    logic [14:0] r_ypre10;

    assign w_c100  = 2'(r_yoe9 >= 9'd100) + 2'(r_yoe9 >= 9'd200) + 2'(r_yoe9 >= 9'd300);
    assign w_yd10  = 18'(r_yoe9) * 18'd365 + 18'(r_yoe9[8:2]) - 18'(w_c100);
    assign w_doy10 = r_doe9 - w_yd10;

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_doy10  <= w_doy10[8:0];
            r_ypre10 <= 15'(r_yoe9) + r_yb9 - YEAR_BIAS;
        end
    end

    // Stage 11: month and day; January and February belong to the next year
    logic [3:0]  w_mp11;
    logic        w_jf11;
    logic [8:0]  w_dom11;
    logic [14:0] w_year11;
    logic [13:0] r_year11;
    logic [3:0]  r_month11;
    logic [4:0]  r_day11;

    assign w_mp11   = march_month(r_doy10);
    assign w_jf11   = (w_mp11 >= 4'd10);
    assign w_dom11  = r_doy10 - month_start(w_mp11) + 9'd1;
    assign w_year11 = r_ypre10 + 15'(w_jf11);

    always_ff @(posedge i_clk) begin
        if (i_en[10]) begin
            r_year11  <= w_year11[13:0];
            r_month11 <= w_jf11 ? (w_mp11 - 4'd9) : (w_mp11 + 4'd3);
            r_day11   <= w_dom11[4:0];
        end
    end

    assign o_year  = r_year11;
    assign o_month = r_month11;
    assign o_day   = r_day11;

endmodule

// ===== rtl/core/ucal_time_of_day.sv =====
// Stages 6-11: milliseconds of the day to hour, minute, second and millisecond.
// Depends on ucal_pkg for the reciprocal constants.

module ucal_time_of_day (
    input  logic                i_clk,
    input  ucal_pkg::t_stage_en i_en,
    input  logic [26:0]         i_msd,
    output logic [4:0]          o_hour,
    output logic [5:0]          o_minute,
    output logic [5:0]          o_second,
    output logic [9:0]          o_millisecond
);
    import ucal_pkg::*;

    // Stage 6: seconds of the day (divide by 8, then by 125)
    logic [48:0] w_p6;
    logic [16:0] r_stot6;
    logic [9:0]  r_mlo6;

    assign w_p6 = 49'(i_msd[26:3]) * 49'(SEC_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_stot6 <= w_p6[SEC_SHIFT+16:SEC_SHIFT];
            r_mlo6  <= i_msd[9:0];
        end
    end

    // Stage 7: millisecond remainder, exact modulo 1024 since it is below 1000
    logic [9:0]  w_ms7;
    logic [9:0]  r_ms7;
    logic [16:0] r_stot7;

    assign w_ms7 = r_mlo6 - 10'(r_stot6 * 17'd1000);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_ms7   <= w_ms7;
            r_stot7 <= r_stot6;
        end
    end

    // Stage 8: minutes of the day
    logic [34:0] w_p8;
    logic [10:0] r_mt8;
    logic [16:0] r_stot8;
    logic [9:0]  r_ms8;

    assign w_p8 = 35'(r_stot7) * 35'(MIN_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_mt8   <= w_p8[MIN_SHIFT+10:MIN_SHIFT];
            r_stot8 <= r_stot7;
            r_ms8   <= r_ms7;
        end
    end

    // Stage 9: second of the minute
    logic [5:0]  w_sec9;
    logic [5:0]  r_sec9;
    logic [10:0] r_mt9;
    logic [9:0]  r_ms9;

    assign w_sec9 = r_stot8[5:0] - 6'(r_mt8 * 11'd60);

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_sec9 <= w_sec9;
            r_mt9  <= r_mt8;
            r_ms9  <= r_ms8;
        end
    end

    // Stage 10: hour of the day
    logic [22:0] w_p10;
    logic [4:0]  r_hr10;
    logic [10:0] r_mt10;
    logic [5:0]  r_sec10;
    logic [9:0]  r_ms10;

    assign w_p10 = 23'(r_mt9) * 23'(HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_hr10  <= w_p10[HOUR_SHIFT+4:HOUR_SHIFT];
            r_mt10  <= r_mt9;
            r_sec10 <= r_sec9;
            r_ms10  <= r_ms9;
        end
    end

    // Stage 11: minute of the hour, worked modulo 64
    logic [5:0] w_min11;
    logic [4:0] r_hr11;
    logic [5:0] r_min11;
    logic [5:0] r_sec11;
    logic [9:0] r_ms11;

    assign w_min11 = r_mt10[5:0] - 6'(r_hr10) * 6'd60;

    always_ff @(posedge i_clk) begin
        if (i_en[10]) begin
            r_hr11  <= r_hr10;
            r_min11 <= w_min11;
            r_sec11 <= r_sec10;
            r_ms11  <= r_ms10;
        end
    end

    assign o_hour        = r_hr11;
    assign o_minute      = r_min11;
    assign o_second      = r_sec11;
    assign o_millisecond = r_ms11;

endmodule

// ===== rtl/core/unix_ms_to_utc_calendar_unit.sv =====
// Unix milliseconds to UTC calendar fields: 11-stage pipeline, throughput one beat per cycle
// unless the output stalls; each stage holds at most one wide constant multiply per path.
// Stages load independently, so empty stages are filled while the output is stalled.
// Synchronous active-low reset clears only the valid bits; data registers are not reset.
// Depends on ucal_pkg, ucal_if, ucal_pipe_ctl, ucal_day_split, ucal_civil_date,
// ucal_time_of_day.

module unix_ms_to_utc_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ucal_ms_if.sink     i_ms,
    ucal_cal_if.source  o_cal
);
    import ucal_pkg::*;

    t_stage_en   w_en;
    logic [22:0] w_zb;
    logic [26:0] w_msd;

    // Valid tracking and stage enables
    ucal_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_ms.valid),
        .i_out_ready (o_cal.ready),
        .o_in_ready  (i_ms.ready),
        .o_out_valid (o_cal.valid),
        .o_en        (w_en)
    );

    // Day number and time of day
    ucal_day_split u_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_unix_ms (i_ms.unix_ms),
        .o_zb      (w_zb),
        .o_msd     (w_msd)
    );

    // Calendar date
    ucal_civil_date u_date (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_zb    (w_zb),
        .o_year  (o_cal.year),
        .o_month (o_cal.month),
        .o_day   (o_cal.day)
    );

    // Clock time
    ucal_time_of_day u_tod (
        .i_clk         (i_clk),
        .i_en          (w_en),
        .i_msd         (w_msd),
        .o_hour        (o_cal.hour),
        .o_minute      (o_cal.minute),
        .o_second      (o_cal.second),
        .o_millisecond (o_cal.millisecond)
    );

endmodule

// ===== rtl/core/ucal_checker.sv =====
// Port-level assertions for unix_ms_to_utc_calendar_unit, attached by bind.
// Depends on nothing beyond the top level's channel ports.

module ucal_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [13:0] i_year,
    input logic [3:0]        i_month,
    input logic [4:0]        i_day,
    input logic [4:0]        i_hour,
    input logic [5:0]        i_minute,
    input logic [5:0]        i_second,
    input logic [9:0]        i_millisecond
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_year) && $stable(i_month)
            && $stable(i_day) && $stable(i_hour) && $stable(i_minute)
            && $stable(i_second) && $stable(i_millisecond))
        else $error("result beat changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Date fields in range
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_month >= 4'd1 && i_month <= 4'd12 && i_day >= 5'd1
            && i_year >= -14'sd2500 && i_year <= 14'sd6500)
        else $error("date field out of range");

    // Day fits the length of its month
    a_month_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_day <= 5'd29) || (i_month != 4'd2 && ((i_day <= 5'd30)
            || i_month == 4'd1 || i_month == 4'd3 || i_month == 4'd5 || i_month == 4'd7
            || i_month == 4'd8 || i_month == 4'd10 || i_month == 4'd12)))
        else $error("day beyond end of month");

    // Time fields in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hour <= 5'd23 && i_minute <= 6'd59 && i_second <= 6'd59
            && i_millisecond <= 10'd999)
        else $error("time field out of range");

endmodule

bind unix_ms_to_utc_calendar_unit ucal_checker u_ucal_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_cal.valid),
    .i_out_ready   (o_cal.ready),
    .i_year        (o_cal.year),
    .i_month       (o_cal.month),
    .i_day         (o_cal.day),
    .i_hour        (o_cal.hour),
    .i_minute      (o_cal.minute),
    .i_second      (o_cal.second),
    .i_millisecond (o_cal.millisecond)
);

// ===== tb/tb_unix_ms_to_utc_calendar_unit.sv =====
// Self-checking testbench for unix_ms_to_utc_calendar_unit: drives timestamps, predicts dates.
// Depends on ucal_pkg, ucal_if and the unit itself; needs no files or arguments.

module tb_unix_ms_to_utc_calendar_unit;
    import ucal_pkg::*;

    localparam int      RANDOM_PER_PHASE = 185;
    localparam int      STUCK_LIMIT      = 4000;
    localparam int      DRAIN_CYCLES     = 3 * STAGES;
    localparam longint  MS_PER_DAY       = 86400000;
    localparam longint  LAST_MS_OF_DAY   = MS_PER_DAY - 1;

    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [9:0]         millisecond;
    } t_calendar;

    logic i_clk;
    logic i_rst_n;

    ucal_ms_if  ms_ch();
    ucal_cal_if cal_ch();

    unix_ms_to_utc_calendar_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ms    (ms_ch),
        .o_cal   (cal_ch)
    );

    logic signed [47:0] stamp_q[$];
    t_calendar          calendar_due[$];

    int idle_pct;
    int stall_pct;
    int errors;
    int stamps_sent;
    int dates_checked;
    int negative_stamps;
    int leap_days_seen;
    int year_lo;
    int year_hi;
    int stuck_cycles;

    // Civil date to day number relative to the epoch
    function automatic longint days_of_date(input longint y, input longint m, input longint d);
        longint yy;
        longint era;
        longint yoe;
        longint doy;
        yy  = (m <= 2) ? y - 1 : y;
        era = ((yy >= 0) ? yy : yy - 399) / 400;
        yoe = yy - era * 400;
        doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
    endfunction

    function automatic logic signed [47:0] stamp_of_date(input longint y, input longint m,
                                                         input longint d, input longint msd);
        return 48'(days_of_date(y, m, d) * MS_PER_DAY + msd);
    endfunction

    // Expected calendar fields for one timestamp: floor split, then era/day-of-era
    function automatic t_calendar civil_from_stamp(input logic signed [47:0] stamp);
        t_calendar c;
        longint t;
        longint days;
        longint msd;
        longint z;
        longint era;
        longint doe;
        longint yoe;
        longint doy;
        longint mp;
        longint m;
        longint y;
        t    = stamp;
        days = t / MS_PER_DAY;
        msd  = t % MS_PER_DAY;
        if (msd < 0) begin
            msd  = msd + MS_PER_DAY;
            days = days - 1;
        end
        z   = days + 719468;
        era = ((z >= 0) ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        c.year        = 14'(y);
        c.month       = 4'(m);
        c.day         = 5'(doy - (153 * mp + 2) / 5 + 1);
        c.hour        = 5'(msd / 3600000);
        c.minute      = 6'((msd / 60000) % 60);
        c.second      = 6'((msd / 1000) % 60);
        c.millisecond = 10'(msd % 1000);
        return c;
    endfunction

    function automatic string calendar_text(input t_calendar c);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d", c.year, c.month, c.day, c.hour,
                         c.minute, c.second, c.millisecond);
    endfunction

    // Random timestamp: raw bits, random dates, month and year edges, small magnitudes
    function automatic logic signed [47:0] random_stamp();
        logic [63:0] raw;
        longint      y;
        longint      m;
        longint      msd;
        int          kind;
        kind = $urandom_range(0, 9);
        raw  = {$urandom(), $urandom()};
        y    = longint'($urandom_range(0, 8800)) - 2400;
        m    = $urandom_range(1, 12);
        case ($urandom_range(0, 2))
            0:       msd = 0;
            1:       msd = LAST_MS_OF_DAY;
            default: msd = $urandom_range(0, 86399999);
        endcase
        if (kind <= 2) begin
            return raw[47:0];
        end else if (kind <= 5) begin
            return stamp_of_date(y, m, $urandom_range(1, 28), $urandom_range(0, 86399999));
        end else if (kind <= 7) begin
            // land on the last or first day of a month, often around a leap day
            if ($urandom_range(0, 1)) begin
                m = 3;
                y = ($urandom_range(0, 1)) ? (y / 100) * 100 : (y / 4) * 4;
            end
            return stamp_of_date(y, m, 1, msd - ($urandom_range(0, 1) ? MS_PER_DAY : 0));
        end else begin
            raw = raw >> $urandom_range(17, 60);
            return $urandom_range(0, 1) ? -$signed(raw[47:0]) : raw[47:0];
        end
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sender: present a new beat once the previous one has gone
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ms_ch.valid <= 1'b0;
        end else begin
            if (ms_ch.valid && ms_ch.ready) begin
                calendar_due.push_back(civil_from_stamp(ms_ch.unix_ms));
                stamps_sent++;
                if (ms_ch.unix_ms < 0) begin
                    negative_stamps++;
                end
            end
            if (!ms_ch.valid || ms_ch.ready) begin
                if (stamp_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    ms_ch.valid   <= 1'b1;
                    ms_ch.unix_ms <= stamp_q.pop_front();
                end else begin
                    ms_ch.valid   <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random and check each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_calendar got;
        t_calendar want;
        if (!i_rst_n) begin
            cal_ch.ready <= 1'b0;
        end else begin
            cal_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            if (cal_ch.valid && cal_ch.ready) begin
                got = '{cal_ch.year, cal_ch.month, cal_ch.day, cal_ch.hour, cal_ch.minute,
                        cal_ch.second, cal_ch.millisecond};
                if (calendar_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected date %s", $time, calendar_text(got));
                end else begin
                    want = calendar_due.pop_front();
                    dates_checked++;
                    if (got !== want) begin
                        errors++;
                        $display("%0t: date mismatch, expected %s, got %s", $time,
                                 calendar_text(want), calendar_text(got));
                    end
                    if (want.month == 4'd2 && want.day == 5'd29) begin
                        leap_days_seen++;
                    end
                    if (int'(want.year) < year_lo) year_lo = want.year;
                    if (int'(want.year) > year_hi) year_hi = want.year;
                end
            end
        end
    end

    // Watchdog: give up when no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((ms_ch.valid && ms_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_unix_ms_to_utc_calendar_unit: errors");
            $finish;
        end
    end

    // Sequence: reset, directed edges, then four phases of mixed idling and stalling
    initial begin
        int phase;
        ms_ch.valid     = 1'b0;
        ms_ch.unix_ms   = '0;
        cal_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        idle_pct        = 0;
        stall_pct       = 0;
        errors          = 0;
        stamps_sent     = 0;
        dates_checked   = 0;
        negative_stamps = 0;
        leap_days_seen  = 0;
        year_lo         = 32767;
        year_hi         = -32768;
        stuck_cycles    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // epoch, sign boundary and the ends of the input range
        stamp_q.push_back(48'sd0);
        stamp_q.push_back(-48'sd1);
        stamp_q.push_back({1'b0, {47{1'b1}}});
        stamp_q.push_back({1'b1, {47{1'b0}}});
        stamp_q.push_back(48'(LAST_MS_OF_DAY));
        stamp_q.push_back(48'(MS_PER_DAY));
        stamp_q.push_back(48'(-MS_PER_DAY));
        stamp_q.push_back(48'(-MS_PER_DAY - 1));
        // leap rules: every fourth year, skipped centuries, kept 400th years
        stamp_q.push_back(stamp_of_date(2000, 2, 29, 45296789));
        stamp_q.push_back(stamp_of_date(2000, 3, 1, 0));
        stamp_q.push_back(stamp_of_date(1900, 2, 28, LAST_MS_OF_DAY));
        stamp_q.push_back(stamp_of_date(1900, 3, 1, 0));
        stamp_q.push_back(stamp_of_date(2100, 2, 28, LAST_MS_OF_DAY));
        stamp_q.push_back(stamp_of_date(2400, 2, 29, 0));
        stamp_q.push_back(stamp_of_date(6400, 2, 29, LAST_MS_OF_DAY));
        stamp_q.push_back(stamp_of_date(-2400, 2, 29, 12345));
        // era boundaries and years around zero
        stamp_q.push_back(stamp_of_date(0, 3, 1, 0));
        stamp_q.push_back(stamp_of_date(0, 3, 1, -1));
        stamp_q.push_back(stamp_of_date(400, 3, 1, 0));
        stamp_q.push_back(stamp_of_date(-1, 12, 31, LAST_MS_OF_DAY));
        stamp_q.push_back(stamp_of_date(1582, 10, 15, 0));
        stamp_q.push_back(stamp_of_date(2024, 12, 31, LAST_MS_OF_DAY));
        stamp_q.push_back(stamp_of_date(1969, 1, 1, 0));

        for (phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 63; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            repeat (RANDOM_PER_PHASE) stamp_q.push_back(random_stamp());
            // wait until every date of this phase has come back
            while (stamp_q.size() > 0 || ms_ch.valid || calendar_due.size() > 0) begin
                @(negedge i_clk);
            end
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (calendar_due.size() > 0) begin
            errors += calendar_due.size();
            $display("%0t: %0d dates never arrived", $time, calendar_due.size());
        end
        $display("Converted %0d timestamps (%0d before the epoch) over four idle/stall mixes,",
                 stamps_sent, negative_stamps);
        $display("checked %0d dates, years %0d to %0d, %0d of them on 29 February.",
                 dates_checked, year_lo, year_hi, leap_days_seen);
        if (errors == 0) begin
            $display("tb_unix_ms_to_utc_calendar_unit: clean");
        end else begin
            $display("tb_unix_ms_to_utc_calendar_unit: errors");
        end
        $finish;
    end

endmodule
